// ===== design/lfu_pkg.sv =====
// Shared types and constants for the LFU slot replacement unit.
package lfu_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CAP_LIMIT = (SLOTS < 16) ? SLOTS : 16;
    localparam logic [15:0] VOTE_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        K_HIT     = 3'd0,
        K_FILL    = 3'd1,
        K_REPLACE = 3'd2,
        K_REPORT  = 3'd3,
        K_EMPTY   = 3'd4
    } t_kind;

    // running victim candidate handed from cell to cell
    typedef struct packed {
        logic [15:0]      votes;
        logic [31:0]      age;
        logic [7:0]       occ;
        logic [IDX_W-1:0] idx;
    } t_best;

    // broadcast write command, qualified per cell by a select bit
    typedef struct packed {
        logic        inc;
        logic        place;
        logic [7:0]  id;
        logic [31:0] stamp;
    } t_cell_cmd;

endpackage

// ===== design/lfu_slot_replacement_unit.sv =====
// Top level of the LFU slot replacement unit: control sequencer around a chain of slot cells.
//
//   channel   direction  handshake              payload
//   in        request    i_in_valid/o_in_stall  i_func, i_candidate_id
//   out       result     o_out_valid/i_out_stall o_kind, o_slot_index, o_occupant_id,
//                                               o_evicted_id, o_vote_count, o_last_result
//   cfg       write      i_cfg_we               i_cfg_data (slot_count)
//
// A hit or a fill is accepted, then compared against all cells at once.
// A replacement first scans: the victim candidate ripples one cell per
// cycle down the chain and is read once it has passed every occupied cell.
// A report issues one result per occupant (a single empty result for an empty set).
// Reset is synchronous: it empties all slots and sets slot_count to 16.
// A stalled output holds its result and holds the sequencer before it issues a result; the next request
// waits until the current one has issued its last result.
module lfu_slot_replacement_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [7:0]  i_candidate_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_slot_index,
    output logic [7:0]  o_occupant_id,
    output logic [7:0]  o_evicted_id,
    output logic [15:0] o_vote_count,
    output logic        o_last_result,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data
);

    localparam int IW = lfu_pkg::IDX_W;
    localparam int NS = lfu_pkg::SLOTS;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_VOTE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_REPL   = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    logic [7:0]   r_id, n_id;
    logic [4:0]   r_slot_count;
    logic [4:0]   r_filled, n_filled;
    logic [31:0]  r_ctr, n_ctr;
    logic [4:0]   r_wait, n_wait;
    logic [4:0]   r_k, n_k;

    logic         r_out_valid, n_out_valid;
    logic [2:0]   r_kind, n_kind;
    logic [3:0]   r_idx, n_idx;
    logic [7:0]   r_occ, n_occ;
    logic [7:0]   r_ev, n_ev;
    logic [15:0]  r_votes, n_votes;
    logic         r_last, n_last;

    logic                   out_free;
    logic                   emit;
    logic [4:0]             cap;
    logic [4:0]             fill_m1;
    lfu_pkg::t_cell_cmd     cmd;
    logic [NS-1:0]          sel;

    logic                   c_valid [NS];
    logic [7:0]             c_occ   [NS];
    logic [15:0]            c_votes [NS];
    logic                   c_match [NS];
    logic [IW-1:0]          c_rank  [NS];
    lfu_pkg::t_best         c_best  [NS];
    lfu_pkg::t_best         c_prev  [NS];
    logic [NS-1:0][7:0]     occ_all;
    logic [NS-1:0]          valid_all;

    logic                   any_match;
    logic [IW-1:0]          m_idx;
    logic [15:0]            m_votes;
    logic [15:0]            m_inc;
    logic [IW-1:0]          rpt_idx;
    logic [7:0]             rpt_occ;
    logic [15:0]            rpt_votes;
    lfu_pkg::t_best         victim;

    // ---- cell chain ----
    for (genvar g = 0; g < NS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign c_prev[g] = c_best[g];
        end else begin : g_link
            assign c_prev[g] = c_best[g-1];
        end
        assign occ_all[g]   = c_occ[g];
        assign valid_all[g] = c_valid[g];

        lfu_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (IW'(g)),
            .i_first     (g == 0),
            .i_sel       (sel[g]),
            .i_cmd       (cmd),
            .i_counter   (r_ctr),
            .i_best      (c_prev[g]),
            .i_occ_all   (occ_all),
            .i_valid_all (valid_all),
            .o_valid     (c_valid[g]),
            .o_occ       (c_occ[g]),
            .o_votes     (c_votes[g]),
            .o_match     (c_match[g]),
            .o_rank      (c_rank[g]),
            .o_best      (c_best[g])
        );
    end

    // usable capacity: slot_count clamped into 1..CAP_LIMIT
    always_comb begin
        if (r_slot_count == 5'd0) begin
            cap = 5'd1;
        end else if (r_slot_count > 5'(lfu_pkg::CAP_LIMIT)) begin
            cap = 5'(lfu_pkg::CAP_LIMIT);
        end else begin
            cap = r_slot_count;
        end
    end

    assign fill_m1 = r_filled - 5'd1;
    assign victim  = c_best[fill_m1[IW-1:0]];

    // hit lookup and report selection, one-hot over the cells
    always_comb begin
        any_match = 1'b0;
        m_idx     = '0;
        m_votes   = '0;
        rpt_idx   = '0;
        rpt_occ   = '0;
        rpt_votes = '0;
        for (int s = 0; s < NS; s++) begin
            if (c_match[s]) begin
                any_match = 1'b1;
                m_idx     = m_idx | IW'(s);
                m_votes   = m_votes | c_votes[s];
            end
            if (c_valid[s] && c_rank[s] == r_k[IW-1:0]) begin
                rpt_idx   = rpt_idx | IW'(s);
                rpt_occ   = rpt_occ | c_occ[s];
                rpt_votes = rpt_votes | c_votes[s];
            end
        end
        m_inc = (m_votes != lfu_pkg::VOTE_MAX) ? m_votes + 16'd1 : m_votes;
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // ---- sequencer ----
    always_comb begin
        n_state   = r_state;
        n_id      = r_id;
        n_filled  = r_filled;
        n_ctr     = r_ctr;
        n_wait    = r_wait;
        n_k       = r_k;
        emit      = 1'b0;
        n_kind    = r_kind;
        n_idx     = r_idx;
        n_occ     = r_occ;
        n_ev      = r_ev;
        n_votes   = r_votes;
        n_last    = r_last;
        cmd.inc   = 1'b0;
        cmd.place = 1'b0;
        cmd.id    = r_id;
        cmd.stamp = r_ctr;
        sel       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_id   = i_candidate_id;
                    n_k    = '0;
                    if (i_func) begin
                        n_state = S_REPORT;
                    end else if (i_candidate_id != 8'd0) begin
                        n_state = S_VOTE;
                    end
                    // drop a vote for id zero
                end
            end
            S_VOTE: begin
                if (any_match) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        n_kind   = lfu_pkg::K_HIT;
                        n_idx    = 4'(m_idx);
                        n_occ    = r_id;
                        n_ev     = 8'd0;
                        n_votes  = m_inc;
                        n_last   = 1'b1;
                        cmd.inc  = 1'b1;
                        sel[m_idx] = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (r_filled < cap) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        n_kind    = lfu_pkg::K_FILL;
                        n_idx     = 4'(r_filled);
                        n_occ     = r_id;
                        n_ev      = 8'd0;
                        n_votes   = 16'd1;
                        n_last    = 1'b1;
                        cmd.place = 1'b1;
                        sel[r_filled[IW-1:0]] = 1'b1;
                        n_filled  = r_filled + 5'd1;
                        n_ctr     = r_ctr + 32'd1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_wait  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // let the candidate ripple past every cell
                n_wait = r_wait + 5'd1;
                if (r_wait == 5'(NS - 1)) begin
                    n_state = S_REPL;
                end
            end
            S_REPL: begin
                if (out_free) begin
                    emit      = 1'b1;
                    n_kind    = lfu_pkg::K_REPLACE;
                    n_idx     = 4'(victim.idx);
                    n_occ     = r_id;
                    n_ev      = victim.occ;
                    n_votes   = 16'd1;
                    n_last    = 1'b1;
                    cmd.place = 1'b1;
                    sel[victim.idx] = 1'b1;
                    n_ctr     = r_ctr + 32'd1;
                    n_state   = S_IDLE;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    emit = 1'b1;
                    n_ev = 8'd0;
                    if (r_filled == 5'd0) begin
                        n_kind  = lfu_pkg::K_EMPTY;
                        n_idx   = 4'd0;
                        n_occ   = 8'd0;
                        n_votes = 16'd0;
                        n_last  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_kind  = lfu_pkg::K_REPORT;
                        n_idx   = 4'(rpt_idx);
                        n_occ   = rpt_occ;
                        n_votes = rpt_votes;
                        n_last  = (r_k + 5'd1 == r_filled);
                        n_k     = r_k + 5'd1;
                        if (r_k + 5'd1 == r_filled) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_filled     <= '0;
            r_ctr        <= '0;
            r_slot_count <= 5'd16;
            r_out_valid  <= 1'b0;
            r_wait       <= '0;
            r_k          <= '0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_ctr       <= n_ctr;
            r_out_valid <= n_out_valid;
            r_wait      <= n_wait;
            r_k         <= n_k;
            if (i_cfg_we) begin
                r_slot_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_kind  <= n_kind;
        r_idx   <= n_idx;
        r_occ   <= n_occ;
        r_ev    <= n_ev;
        r_votes <= n_votes;
        r_last  <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_slot_index  = r_idx;
    assign o_occupant_id = r_occ;
    assign o_evicted_id  = r_ev;
    assign o_vote_count  = r_votes;
    assign o_last_result = r_last;

endmodule

// ===== design/lfu_cell.sv =====
// One slot cell: holds occupant, votes and stamp, ranks itself and forwards the victim candidate.
module lfu_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [lfu_pkg::IDX_W-1:0]            i_index,
    input  logic                                 i_first,
    input  logic                                 i_sel,
    input  lfu_pkg::t_cell_cmd                   i_cmd,
    input  logic [31:0]                          i_counter,
    input  lfu_pkg::t_best                       i_best,
    input  logic [lfu_pkg::SLOTS-1:0][7:0]       i_occ_all,
    input  logic [lfu_pkg::SLOTS-1:0]            i_valid_all,
    output logic                                 o_valid,
    output logic [7:0]                           o_occ,
    output logic [15:0]                          o_votes,
    output logic                                 o_match,
    output logic [lfu_pkg::IDX_W-1:0]            o_rank,
    output lfu_pkg::t_best                       o_best
);

    logic                        r_valid;
    logic [7:0]                  r_occ;
    logic [15:0]                 r_votes;
    logic [31:0]                 r_stamp;
    logic [lfu_pkg::IDX_W-1:0]   r_rank;
    logic [lfu_pkg::IDX_W:0]     n_rank;
    lfu_pkg::t_best              r_best;
    lfu_pkg::t_best              self_b;
    logic                        better;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_sel && i_cmd.place) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel && i_cmd.place) begin
            r_occ   <= i_cmd.id;
            r_votes <= 16'd1;
            r_stamp <= i_cmd.stamp;
        end else if (i_sel && i_cmd.inc && r_votes != lfu_pkg::VOTE_MAX) begin
            r_votes <= r_votes + 16'd1;
        end
    end

    // count valid occupants with a smaller id
    always_comb begin
        n_rank = '0;
        for (int j = 0; j < lfu_pkg::SLOTS; j++) begin
            if (i_valid_all[j] && i_occ_all[j] < r_occ) begin
                n_rank = n_rank + 1'b1;
            end
        end
    end

    always_comb begin
        self_b.votes = r_votes;
        self_b.age   = i_counter - r_stamp;
        self_b.occ   = r_occ;
        self_b.idx   = i_index;
        better = (r_votes < i_best.votes) ||
                 (r_votes == i_best.votes && self_b.age > i_best.age);
    end

    always_ff @(posedge i_clk) begin
        r_rank <= n_rank[lfu_pkg::IDX_W-1:0];
        r_best <= (i_first || better) ? self_b : i_best;
    end

    assign o_valid = r_valid;
    assign o_occ   = r_occ;
    assign o_votes = r_votes;
    assign o_match = r_valid && (r_occ == i_cmd.id);
    assign o_rank  = r_rank;
    assign o_best  = r_best;

endmodule

// ===== design/lfu_checker.sv =====
// Port-level checker for the LFU slot replacement unit, bound to the top level.
module lfu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_occupant_id,
    input logic [7:0]  o_evicted_id,
    input logic [15:0] o_vote_count,
    input logic        o_last_result
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != lfu_pkg::K_REPLACE |-> o_evicted_id == 8'd0)
        else $error("evicted id outside a replacement");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != lfu_pkg::K_REPORT |-> o_last_result)
        else $error("single result not marked last");

    a_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == lfu_pkg::K_FILL || o_kind == lfu_pkg::K_REPLACE)
        |-> o_vote_count == 16'd1 && o_occupant_id != 8'd0)
        else $error("new occupant must start at one vote");

endmodule

bind lfu_slot_replacement_unit lfu_checker u_lfu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kind        (o_kind),
    .o_occupant_id (o_occupant_id),
    .o_evicted_id  (o_evicted_id),
    .o_vote_count  (o_vote_count),
    .o_last_result (o_last_result)
);
